// File: hw/rtl/gfi_pkg.sv
// gfi_pkg: shared types, constants and the field multiply for the gf(2^8) inverse unit
`default_nettype none

package gfi_pkg;

    localparam int unsigned GF_W = 8;

    typedef logic [GF_W-1:0] t_byte;

    // reduction polynomial without the x^8 term (0x11b)
    localparam t_byte GF_POLY_LOW = 8'h1B;

    // square-and-multiply rounds taking a to a^127
    localparam logic [2:0] ROUNDS = 3'd6;

    typedef struct packed {
        logic load;
        logic square;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic t_byte gf_mul(input t_byte x, input t_byte y);
        t_byte acc;
        t_byte addend;
        logic  carry;
        acc    = '0;
        addend = x;
        for (int k = 0; k < GF_W; k++) begin
            if (y[k]) begin
                acc = acc ^ addend;
            end
            carry  = addend[GF_W-1];
            addend = {addend[GF_W-2:0], 1'b0};
            if (carry) begin
                addend = addend ^ GF_POLY_LOW;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gfi_if.sv
// gfi_if: valid/ready channels for the input value and the result inverse
`default_nettype none

interface gfi_value_if;
    import gfi_pkg::*;
    logic  valid;
    logic  ready;
    t_byte value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface gfi_inverse_if;
    import gfi_pkg::*;
    logic  valid;
    logic  ready;
    t_byte inverse;
    modport source (output valid, output inverse, input ready);
    modport sink (input valid, input inverse, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gfi_ctrl.sv
// gfi_ctrl: sequencer for the square-and-multiply inversion
`default_nettype none

module gfi_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output gfi_pkg::t_cmd        o_cmd,
    input  wire gfi_pkg::t_status i_status
);
    import gfi_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = r_cnt + 3'd1;
                if (r_cnt == ROUNDS - 3'd1) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_FIN: begin
                o_cmd.square = 1'b1;
                n_state      = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SQ && r_cnt == 3'd0))
        else $error("accepted item did not start the square pass");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ROUNDS)
        else $error("round counter out of range");

    a_mul_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_SQ || r_state == ST_FIN))
        else $error("multiply pass not followed by square");

endmodule

`default_nettype wire

// File: hw/rtl/gfi_datapath.sv
// gfi_datapath: operand, accumulator and result registers around one field multiplier
`default_nettype none

module gfi_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gfi_pkg::t_byte    i_value,
    input  wire gfi_pkg::t_cmd     i_cmd,
    output gfi_pkg::t_status       o_status,
    output gfi_pkg::t_byte         o_inverse,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready
);
    import gfi_pkg::*;

    t_byte r_a;
    t_byte r_acc;
    t_byte r_out;
    logic  r_out_valid;
    t_byte op_b;
    t_byte product;

    assign op_b    = i_cmd.mul ? r_a : r_acc;
    assign product = gf_mul(r_acc, op_b);

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_inverse         = r_out;
    assign o_out_valid       = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_value;
            r_acc <= i_value;
        end else if (i_cmd.square || i_cmd.mul) begin
            r_acc <= product;
        end
        if (i_cmd.emit) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// File: hw/rtl/gf256_multiplicative_inverse_unit.sv
// gf256_multiplicative_inverse_unit: top level of the gf(2^8) inverse unit
`default_nettype none

// Returns the multiplicative inverse of a byte in GF(2^8) modulo x^8+x^4+x^3+x+1,
// with zero mapped to zero. The inverse is formed as a^254 by six square-then-multiply
// rounds (a^127) and one final square, all through a single shared field multiplier,
// one multiply per cycle. An accepted item runs through the square and multiply passes,
// the final square and the wait state that moves the result into the output register;
// no new item is accepted until then. The result register lets the next item be
// accepted while the previous result still waits to be taken; a stalled result only
// holds the unit once the next inversion has finished.
module gf256_multiplicative_inverse_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gfi_value_if.sink  i_value,
    gfi_inverse_if.source o_inverse
);
    import gfi_pkg::*;

    t_cmd    cmd;
    t_status status;

    gfi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value.valid),
        .o_in_ready (i_value.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    gfi_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value.value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_inverse   (o_inverse.inverse),
        .o_out_valid (o_inverse.valid),
        .i_out_ready (o_inverse.ready)
    );

endmodule

`default_nettype wire
